FILE: src/hkc_pkg.sv
// ----------------------------------------------------------------------------
// Hermite keyframe curve package
// Shared types, action codes and command structures for the curve core.
// ----------------------------------------------------------------------------
package hkc_pkg;

    localparam int MaxKeys = 16;
    localparam int SlotW = $clog2(MaxKeys);
    localparam int CountW = 5;

    localparam logic [2:0] ACT_LOAD = 3'd0;
    localparam logic [2:0] ACT_SETVAL = 3'd1;
    localparam logic [2:0] ACT_SETDER = 3'd2;
    localparam logic [2:0] ACT_READ = 3'd3;
    localparam logic [2:0] ACT_EVAL = 3'd4;

    typedef struct packed {
        logic capture;
        logic load_key;
        logic scan_clear;
        logic scan_step;
        logic scan_done;
        logic seg_step;
        logic write_nearest;
        logic div_start;
        logic div_step;
        logic mul_step;
        logic finish;
    } hkc_cmd_t;

    typedef struct packed {
        logic [2:0] action;
        logic slot_ok;
        logic scan_last;
        logic seg_last;
        logic div_last;
        logic mul_last;
    } hkc_status_t;

endpackage

FILE: src/hkc_datapath.sv
// ----------------------------------------------------------------------------
// Hermite keyframe curve datapath
// Key tables, nearest and segment scans, serial divider and the multiplies for the powers of t and the basis terms.
// ----------------------------------------------------------------------------
module hkc_datapath
(
    input  logic                clk,
    input  logic                rst_n,
    input  hkc_pkg::hkc_cmd_t   cmd,
    output hkc_pkg::hkc_status_t status,
    input  logic [2:0]          action,
    input  logic [3:0]          key_slot,
    input  logic [15:0]         time_in,
    input  logic signed [15:0]  value_in,
    input  logic signed [15:0]  deriv_in,
    input  logic [4:0]          key_count_val,
    output logic signed [15:0]  curve_value,
    output logic signed [15:0]  nearest_value,
    output logic signed [15:0]  nearest_deriv,
    output logic [3:0]          nearest_slot
);
    import hkc_pkg::*;

    logic [15:0] times_reg [MaxKeys];
    logic signed [15:0] values_reg [MaxKeys];
    logic signed [15:0] derivs_reg [MaxKeys];

    logic [2:0] act_reg;
    logic [SlotW-1:0] slot_reg;
    logic slot_ok_reg;
    logic [15:0] tm_reg;
    logic signed [15:0] val_reg;
    logic signed [15:0] der_reg;
    logic [SlotW-1:0] last_idx;

    logic [SlotW-1:0] idx_reg;
    logic [SlotW-1:0] best_reg;
    logic [15:0] bestd_reg;
    logic [SlotW-1:0] seg_reg;
    logic found_reg;
    logic [1:0] mode_reg;

    logic [16:0] rem_reg;
    logic [16:0] quo_reg;
    logic [15:0] span_reg;
    logic [4:0] dcnt_reg;
    logic [15:0] dnum_reg;

    logic [2:0] mcnt_reg;
    logic [16:0] t_reg;
    logic [16:0] t2_reg;
    logic [16:0] t3_reg;
    logic signed [47:0] acc_reg;

    logic signed [15:0] curve_reg;
    logic signed [15:0] nval_reg;
    logic signed [15:0] nder_reg;
    logic [SlotW-1:0] nslot_reg;

    logic [15:0] cur_t;
    logic [15:0] key_gap;
    logic [15:0] next_t;
    logic [15:0] seg_off;
    logic [17:0] trial;
    logic signed [18:0] basis;
    logic signed [15:0] coef;
    logic signed [35:0] prod;
    logic [33:0] uprod;
    logic signed [47:0] rsum;
    logic signed [31:0] rshift;
    logic signed [15:0] sat;

    always_comb
    begin
        if (key_count_val < 5'd2)
            last_idx = SlotW'(1);
        else if (key_count_val > 5'(MaxKeys))
            last_idx = SlotW'(MaxKeys - 1);
        else
            last_idx = SlotW'(key_count_val - 5'd1);
    end

    assign cur_t = times_reg[idx_reg];
    assign next_t = times_reg[idx_reg + SlotW'(1)];
    assign key_gap = (cur_t > tm_reg) ? cur_t - tm_reg : tm_reg - cur_t;
    assign seg_off = tm_reg - times_reg[seg_reg];
    assign trial = {rem_reg, dnum_reg[15]} - {2'b00, span_reg};

    always_comb
    begin
        basis = '0;
        coef = '0;
        case (mcnt_reg)
            3'd3:
            begin
                basis = 19'sd65536 + 19'(signed'({2'b0, t3_reg}) * 2)
                        - 19'(signed'({2'b0, t2_reg}) * 3);
                coef = values_reg[seg_reg];
            end
            3'd4:
            begin
                basis = signed'({2'b0, t3_reg}) - 19'(signed'({2'b0, t2_reg}) * 2)
                        + signed'({2'b0, t_reg});
                coef = derivs_reg[seg_reg];
            end
            3'd5:
            begin
                basis = 19'(signed'({2'b0, t2_reg}) * 3)
                        - 19'(signed'({2'b0, t3_reg}) * 2);
                coef = values_reg[seg_reg + SlotW'(1)];
            end
            3'd6:
            begin
                basis = signed'({2'b0, t3_reg}) - signed'({2'b0, t2_reg});
                coef = derivs_reg[seg_reg + SlotW'(1)];
            end
            default:
            begin
                basis = '0;
                coef = '0;
            end
        endcase
    end

    assign prod = 36'(coef * basis);
    assign uprod = (mcnt_reg == 3'd1) ? 34'(t_reg * t_reg) : 34'(t2_reg * t_reg);
    assign rsum = acc_reg + 48'sd32768;
    assign rshift = 32'(rsum >>> 16);
    assign sat = (rshift > 32'sd32767) ? 16'sh7fff :
                 (rshift < -32'sd32768) ? 16'sh8000 : rshift[15:0];

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg <= action;
            slot_reg <= key_slot[SlotW-1:0];
            slot_ok_reg <= (32'(key_slot) < MaxKeys);
            tm_reg <= time_in;
            val_reg <= value_in;
            der_reg <= deriv_in;
        end
        if (cmd.scan_clear)
        begin
            idx_reg <= '0;
            best_reg <= '0;
            bestd_reg <= 16'hffff;
            found_reg <= 1'b0;
            seg_reg <= '0;
            mode_reg <= 2'd0;
        end
        else if (cmd.scan_step)
        begin
            if (idx_reg == '0 || key_gap < bestd_reg)
            begin
                bestd_reg <= key_gap;
                best_reg <= idx_reg;
            end
            idx_reg <= idx_reg + SlotW'(1);
        end
        else if (cmd.scan_done)
        begin
            idx_reg <= '0;
            if (tm_reg > times_reg[last_idx])
            begin
                mode_reg <= 2'd1;
                seg_reg <= last_idx;
            end
        end
        else if (cmd.seg_step)
        begin
            if (!found_reg && mode_reg == 2'd0 && tm_reg >= cur_t && tm_reg <= next_t)
            begin
                found_reg <= 1'b1;
                seg_reg <= idx_reg;
                if (next_t == cur_t)
                    mode_reg <= 2'd1;
            end
            idx_reg <= idx_reg + SlotW'(1);
        end
        if (cmd.div_start)
        begin
            if (mode_reg == 2'd0 && !found_reg)
            begin
                mode_reg <= 2'd1;
                seg_reg <= '0;
            end
            rem_reg <= {2'b00, seg_off[15:1]};
            quo_reg <= '0;
            dcnt_reg <= '0;
            span_reg <= times_reg[seg_reg + SlotW'(1)] - times_reg[seg_reg];
            dnum_reg <= {seg_off[0], 15'd0};
        end
        else if (cmd.div_step)
        begin
            dnum_reg <= {dnum_reg[14:0], 1'b0};
            if (!trial[17])
            begin
                rem_reg <= trial[16:0];
                quo_reg <= {quo_reg[15:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[15:0], dnum_reg[15]};
                quo_reg <= {quo_reg[15:0], 1'b0};
            end
            dcnt_reg <= dcnt_reg + 5'd1;
        end
        if (cmd.div_start)
            mcnt_reg <= '0;
        else if (cmd.mul_step)
        begin
            case (mcnt_reg)
                3'd0:
                begin
                    t_reg <= quo_reg;
                    acc_reg <= '0;
                end
                3'd1: t2_reg <= 17'(uprod >> 16);
                3'd2: t3_reg <= 17'(uprod >> 16);
                default: acc_reg <= acc_reg + 48'(prod);
            endcase
            mcnt_reg <= mcnt_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MaxKeys; i++)
            begin
                times_reg[i] <= '0;
                values_reg[i] <= '0;
                derivs_reg[i] <= '0;
            end
        end
        else if (cmd.load_key && slot_ok_reg)
        begin
            times_reg[slot_reg] <= tm_reg;
            values_reg[slot_reg] <= val_reg;
            derivs_reg[slot_reg] <= der_reg;
        end
        else if (cmd.write_nearest)
        begin
            if (act_reg == ACT_SETVAL)
                values_reg[best_reg] <= val_reg;
            else if (act_reg == ACT_SETDER)
                derivs_reg[best_reg] <= der_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            if (act_reg == ACT_LOAD || act_reg > ACT_EVAL)
            begin
                curve_reg <= '0;
                nval_reg <= '0;
                nder_reg <= '0;
                nslot_reg <= '0;
            end
            else
            begin
                nval_reg <= values_reg[best_reg];
                nder_reg <= derivs_reg[best_reg];
                nslot_reg <= best_reg;
                if (act_reg != ACT_EVAL)
                    curve_reg <= '0;
                else if (mode_reg == 2'd1)
                    curve_reg <= values_reg[seg_reg];
                else
                    curve_reg <= sat;
            end
        end
    end

    assign status.action = act_reg;
    assign status.slot_ok = slot_ok_reg;
    assign status.scan_last = (idx_reg == last_idx);
    assign status.seg_last = (idx_reg + SlotW'(1) == last_idx) || (mode_reg != 2'd0);
    assign status.div_last = (dcnt_reg == 5'd16) || (mode_reg != 2'd0);
    assign status.mul_last = (mcnt_reg == 3'd6) || (mode_reg != 2'd0);

    assign curve_value = curve_reg;
    assign nearest_value = nval_reg;
    assign nearest_deriv = nder_reg;
    assign nearest_slot = 4'(nslot_reg);

endmodule

FILE: src/hkc_control.sv
// ----------------------------------------------------------------------------
// Hermite keyframe curve controller
// Sequences capture, scans, division, multiplies and the result strobe.
// ----------------------------------------------------------------------------
module hkc_control
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    output logic                 done,
    output hkc_pkg::hkc_cmd_t    cmd,
    input  hkc_pkg::hkc_status_t status
);
    import hkc_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_DECODE = 4'd1;
    localparam logic [3:0] ST_SCAN = 4'd2;
    localparam logic [3:0] ST_WRITE = 4'd3;
    localparam logic [3:0] ST_SEG = 4'd4;
    localparam logic [3:0] ST_DIVSET = 4'd5;
    localparam logic [3:0] ST_DIV = 4'd6;
    localparam logic [3:0] ST_MUL = 4'd7;
    localparam logic [3:0] ST_FINISH = 4'd8;
    localparam logic [3:0] ST_OUT = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                cmd.scan_clear = 1'b1;
                if (status.action == ACT_LOAD)
                begin
                    cmd.load_key = 1'b1;
                    state_next = ST_FINISH;
                end
                else if (status.action > ACT_EVAL)
                    state_next = ST_FINISH;
                else
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                    state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                cmd.write_nearest = 1'b1;
                if (status.action == ACT_EVAL)
                begin
                    cmd.scan_done = 1'b1;
                    state_next = ST_SEG;
                end
                else
                    state_next = ST_FINISH;
            end
            ST_SEG:
            begin
                cmd.seg_step = 1'b1;
                if (status.seg_last)
                    state_next = ST_DIVSET;
            end
            ST_DIVSET:
            begin
                cmd.div_start = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (status.mul_last)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_OUT);

endmodule

FILE: src/hermite_keyframe_curve_core.sv
// ----------------------------------------------------------------------------
// Hermite keyframe curve core
// Keyframe table with nearest-key access and cubic Hermite evaluation.
// ----------------------------------------------------------------------------
// Channel   Signals                                      Handshake
// request   action key_slot time_in value_in deriv_in    start, taken when !busy
// result    curve_value nearest_* nearest_slot           done, one cycle
// config    key_count_wdata                              key_count_we
//
// A load skips the key scans; a read or set runs the nearest-key scan, and an
// evaluation runs both key scans (one key per cycle), 17 divider steps and 7
// multiply steps. A query past the last key, on an empty segment or outside
// every segment returns a key value and ends the divider and multiply steps
// early.
// Reset clears the key table and sets the key count to two.
// The result strobe cannot be stalled; busy stays high until it has shown.
module hermite_keyframe_curve_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    output logic                done,
    input  logic [2:0]          action,
    input  logic [3:0]          key_slot,
    input  logic [15:0]         time_in,
    input  logic signed [15:0]  value_in,
    input  logic signed [15:0]  deriv_in,
    input  logic                key_count_we,
    input  logic [4:0]          key_count_wdata,
    output logic signed [15:0]  curve_value,
    output logic signed [15:0]  nearest_value,
    output logic signed [15:0]  nearest_deriv,
    output logic [3:0]          nearest_slot
);
    import hkc_pkg::*;

    hkc_cmd_t cmd;
    hkc_status_t status;
    logic [CountW-1:0] key_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            key_count_reg <= CountW'(2);
        else if (key_count_we)
            key_count_reg <= key_count_wdata;
    end

    hkc_control u_control
    (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .done(done),
        .cmd(cmd),
        .status(status)
    );

    hkc_datapath u_datapath
    (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(cmd),
        .status(status),
        .action(action),
        .key_slot(key_slot),
        .time_in(time_in),
        .value_in(value_in),
        .deriv_in(deriv_in),
        .key_count_val(key_count_reg),
        .curve_value(curve_value),
        .nearest_value(nearest_value),
        .nearest_deriv(nearest_deriv),
        .nearest_slot(nearest_slot)
    );

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n) done |-> busy)
        else $error("Result strobe without a request in flight.");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("Result strobe held longer than one cycle.");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("Accepted request did not raise busy.");

endmodule

FILE: sim/hermite_keyframe_curve_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Hermite keyframe curve core testbench
// Drives load, set, read and evaluate requests with random gaps, predicts
// every result from a local copy of the key table and compares each strobe.
// ----------------------------------------------------------------------------
module hermite_keyframe_curve_core_test;
    import hkc_pkg::*;

    typedef struct {
        logic [2:0]         action;
        logic [3:0]         slot;
        logic [15:0]        tm;
        logic signed [15:0] val;
        logic signed [15:0] der;
        int                 gap;
        bit                 is_cfg;
        logic [4:0]         cfg;
        bit                 drain;
    } request_t;

    typedef struct {
        logic signed [15:0] curve;
        logic signed [15:0] nval;
        logic signed [15:0] nder;
        logic [3:0]         nslot;
    } curve_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic done;
    logic [2:0] action = '0;
    logic [3:0] key_slot = '0;
    logic [15:0] time_in = '0;
    logic signed [15:0] value_in = '0;
    logic signed [15:0] deriv_in = '0;
    logic key_count_we = 1'b0;
    logic [4:0] key_count_wdata = '0;
    logic signed [15:0] curve_value;
    logic signed [15:0] nearest_value;
    logic signed [15:0] nearest_deriv;
    logic [3:0] nearest_slot;

    logic [15:0] tbl_time [MaxKeys];
    logic signed [15:0] tbl_val [MaxKeys];
    logic signed [15:0] tbl_der [MaxKeys];
    logic [4:0] count_reg;

    request_t pending_q[$];
    curve_result_t expected_q[$];
    int errors = 0;
    int cycles = 0;
    int evals_seen = 0;
    int results_seen = 0;

    int wait_cnt = 0;
    bit holding = 1'b0;
    bit req_taken = 1'b0;
    request_t cur;
    request_t pending_req;

    hermite_keyframe_curve_core u_top
    (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
        .action(action), .key_slot(key_slot), .time_in(time_in),
        .value_in(value_in), .deriv_in(deriv_in),
        .key_count_we(key_count_we), .key_count_wdata(key_count_wdata),
        .curve_value(curve_value), .nearest_value(nearest_value),
        .nearest_deriv(nearest_deriv), .nearest_slot(nearest_slot)
    );

    always #5 clk = ~clk;

    function automatic int keys_used();
        int n;
        n = count_reg;
        if (n < 2) n = 2;
        if (n > MaxKeys) n = MaxKeys;
        return n;
    endfunction

    function automatic int find_nearest(logic [15:0] tm);
        int best;
        int bestd;
        int d;
        best = 0;
        bestd = (tbl_time[0] > tm) ? tbl_time[0] - tm : tm - tbl_time[0];
        for (int i = 1; i < keys_used(); i++)
        begin
            d = (tbl_time[i] > tm) ? tbl_time[i] - tm : tm - tbl_time[i];
            if (d < bestd)
            begin
                bestd = d;
                best = i;
            end
        end
        return best;
    endfunction

    function automatic logic signed [15:0] hermite_at(logic [15:0] tm);
        int n;
        longint a, b, span, t, t2, t3, s, r;
        n = keys_used();
        if (tm > tbl_time[n-1]) return tbl_val[n-1];
        for (int i = 0; i + 1 < n; i++)
        begin
            a = tbl_time[i];
            b = tbl_time[i+1];
            if (tm >= a && tm <= b)
            begin
                span = b - a;
                if (span == 0) return tbl_val[i];
                t = ((longint'(tm) - a) <<< 16) / span;
                t2 = (t * t) >>> 16;
                t3 = (t2 * t) >>> 16;
                s = longint'(tbl_val[i]) * (2*t3 - 3*t2 + 65536)
                  + longint'(tbl_der[i]) * (t3 - 2*t2 + t)
                  + longint'(tbl_val[i+1]) * (-2*t3 + 3*t2)
                  + longint'(tbl_der[i+1]) * (t3 - t2);
                s = s + 32768;
                if (s >= 0) r = s >>> 16;
                else r = -((-s + 65535) >>> 16);
                if (r > 32767) r = 32767;
                if (r < -32768) r = -32768;
                return r[15:0];
            end
        end
        return tbl_val[0];
    endfunction

    function automatic curve_result_t apply_request(request_t rq);
        curve_result_t res;
        int k;
        res = '{default: '0};
        if (rq.action == ACT_LOAD)
        begin
            tbl_time[rq.slot] = rq.tm;
            tbl_val[rq.slot] = rq.val;
            tbl_der[rq.slot] = rq.der;
            return res;
        end
        if (rq.action > ACT_EVAL) return res;
        k = find_nearest(rq.tm);
        if (rq.action == ACT_SETVAL) tbl_val[k] = rq.val;
        else if (rq.action == ACT_SETDER) tbl_der[k] = rq.der;
        else if (rq.action == ACT_EVAL) res.curve = hermite_at(rq.tm);
        res.nval = tbl_val[k];
        res.nder = tbl_der[k];
        res.nslot = k[3:0];
        return res;
    endfunction

    function automatic request_t make_req(logic [2:0] act, logic [3:0] sl, logic [15:0] tm,
                                          logic [15:0] v, logic [15:0] d);
        request_t rq;
        rq.action = act;
        rq.slot = sl;
        rq.tm = tm;
        rq.val = v;
        rq.der = d;
        rq.gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
        rq.is_cfg = 1'b0;
        rq.cfg = '0;
        rq.drain = 1'b0;
        return rq;
    endfunction

    function automatic request_t make_cfg(logic [4:0] c);
        request_t rq;
        rq = make_req(ACT_LOAD, 4'd0, 16'd0, 16'd0, 16'd0);
        rq.is_cfg = 1'b1;
        rq.cfg = c;
        return rq;
    endfunction

    function automatic void queue_req(request_t rq);
        pending_q.insert(pending_q.size(), rq);
    endfunction

    // Driver: waits for the gap, then holds start until the core takes it.
    // Configuration writes and drain points wait until nothing is in flight.
    always @(negedge clk)
    begin
        if (holding && req_taken)
        begin
            holding = 1'b0;
            req_taken = 1'b0;
        end
        if (!rst_n)
        begin
            start <= 1'b0;
            key_count_we <= 1'b0;
        end
        else if (holding)
        begin
            start <= 1'b1;
            key_count_we <= 1'b0;
        end
        else if (pending_q.size() == 0)
        begin
            start <= 1'b0;
            key_count_we <= 1'b0;
        end
        else if (pending_q[0].is_cfg || pending_q[0].drain)
        begin
            start <= 1'b0;
            if (busy || expected_q.size() != 0)
            begin
                key_count_we <= 1'b0;
            end
            else
            begin
                cur = pending_q.pop_front();
                wait_cnt = 0;
                if (cur.is_cfg)
                begin
                    key_count_we <= 1'b1;
                    key_count_wdata <= cur.cfg;
                end
                else
                begin
                    key_count_we <= 1'b0;
                end
            end
        end
        else if (wait_cnt < pending_q[0].gap)
        begin
            start <= 1'b0;
            key_count_we <= 1'b0;
            wait_cnt++;
        end
        else
        begin
            cur = pending_q.pop_front();
            wait_cnt = 0;
            action <= cur.action;
            key_slot <= cur.slot;
            time_in <= cur.tm;
            value_in <= cur.val;
            deriv_in <= cur.der;
            start <= 1'b1;
            key_count_we <= 1'b0;
            holding = 1'b1;
            pending_req = cur;
        end
    end

    // Monitor: predicts on acceptance, checks on every strobe.
    curve_result_t got;
    curve_result_t want;
    always @(posedge clk)
    begin
        cycles++;
        if (rst_n && key_count_we)
            count_reg = key_count_wdata;
        if (rst_n && start && !busy)
        begin
            expected_q.insert(expected_q.size(), apply_request(pending_req));
            req_taken = 1'b1;
            if (pending_req.action == ACT_EVAL) evals_seen++;
        end
        if (rst_n && done)
        begin
            results_seen++;
            got.curve = curve_value;
            got.nval = nearest_value;
            got.nder = nearest_deriv;
            got.nslot = nearest_slot;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result, curve_value %0d", got.curve);
                errors++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (got.curve !== want.curve)
                begin
                    $error("curve_value expected %0d actual %0d", want.curve, got.curve);
                    errors++;
                end
                if (got.nval !== want.nval)
                begin
                    $error("nearest_value expected %0d actual %0d", want.nval, got.nval);
                    errors++;
                end
                if (got.nder !== want.nder)
                begin
                    $error("nearest_deriv expected %0d actual %0d", want.nder, got.nder);
                    errors++;
                end
                if (got.nslot !== want.nslot)
                begin
                    $error("nearest_slot expected %0d actual %0d", want.nslot, got.nslot);
                    errors++;
                end
            end
        end
        if (cycles > 600000)
        begin
            $display("timeout with %0d results outstanding", expected_q.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [15:0] rnd16();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000;
            3: return 16'h7FFF;
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic load_sorted(int n, bit tight);
        logic [15:0] t;
        t = 16'($urandom_range(0, 2000));
        for (int i = 0; i < n; i++)
        begin
            queue_req(make_req(ACT_LOAD, 4'(i), t,
                tight ? 16'($urandom_range(0, 1023) - 512) : rnd16(),
                tight ? 16'($urandom_range(0, 2047) - 1024) : rnd16()));
            t = t + 16'($urandom_range(0, 7) == 0 ? 0 : $urandom_range(1, 4000));
        end
    endtask

    task automatic drain_point();
        request_t rq;
        rq = make_req(3'd7, 4'd0, 16'd0, 16'd0, 16'd0);
        rq.drain = 1'b1;
        queue_req(rq);
    endtask

    initial
    begin
        int n;
        request_t rq;
        for (int i = 0; i < MaxKeys; i++)
        begin
            tbl_time[i] = '0;
            tbl_val[i] = '0;
            tbl_der[i] = '0;
        end
        count_reg = 5'd2;
        pending_req = make_req(ACT_LOAD, 4'd0, 16'd0, 16'd0, 16'd0);

        // Directed: extremes, each action, equal times, ties, unused codes.
        queue_req(make_req(ACT_EVAL, 0, 16'h1234, 0, 0));
        queue_req(make_req(ACT_LOAD, 0, 16'h0000, 16'h7FFF, 16'h7FFF));
        queue_req(make_req(ACT_LOAD, 1, 16'hFFFF, 16'h8000, 16'h8000));
        queue_req(make_req(ACT_EVAL, 0, 16'h8000, 0, 0));
        queue_req(make_req(ACT_EVAL, 0, 16'hFFFF, 0, 0));
        queue_req(make_req(ACT_EVAL, 0, 16'h0000, 0, 0));
        queue_req(make_req(ACT_READ, 0, 16'h7FFF, 0, 0));
        queue_req(make_req(ACT_READ, 0, 16'h8000, 0, 0));
        queue_req(make_req(ACT_SETVAL, 0, 16'h0100, 16'h4000, 16'h1111));
        queue_req(make_req(ACT_SETDER, 0, 16'hFF00, 16'h2222, 16'hC000));
        queue_req(make_req(ACT_LOAD, 15, 16'h5000, 16'h0100, 16'h0200));
        queue_req(make_req(ACT_LOAD, 2, 16'h0500, 16'h0300, 16'h0000));
        queue_req(make_req(ACT_LOAD, 1, 16'h0500, 16'h0400, 16'h0000));
        queue_req(make_req(3'd5, 3, 16'h0500, 16'h0001, 16'h0001));
        queue_req(make_req(3'd6, 3, 16'h0500, 16'h0001, 16'h0001));
        queue_req(make_req(3'd7, 3, 16'h0500, 16'h0001, 16'h0001));
        queue_req(make_cfg(5'd3));
        queue_req(make_req(ACT_EVAL, 0, 16'h0500, 0, 0));
        queue_req(make_req(ACT_EVAL, 0, 16'h0400, 0, 0));
        queue_req(make_cfg(5'd0));
        queue_req(make_req(ACT_READ, 0, 16'h0500, 0, 0));
        queue_req(make_cfg(5'd31));
        queue_req(make_req(ACT_EVAL, 0, 16'h6000, 0, 0));
        queue_req(make_req(ACT_READ, 0, 16'h6000, 0, 0));

        // Random phases: fresh sorted table, then queries with random content.
        for (int ph = 0; ph < 24; ph++)
        begin
            case (ph % 6)
                0: n = 2;
                1: n = 16;
                2: n = 1;
                3: n = 17 + $urandom_range(0, 14);
                default: n = $urandom_range(2, 16);
            endcase
            queue_req(make_cfg(n[4:0]));
            load_sorted(16, (ph % 2) == 1);
            for (int j = 0; j < 42; j++)
            begin
                case ($urandom_range(0, 19))
                    0: rq = make_req(ACT_LOAD, 4'($urandom()), rnd16(), rnd16(), rnd16());
                    1: rq = make_req(3'($urandom_range(5, 7)), 4'($urandom()), rnd16(),
                                     rnd16(), rnd16());
                    2, 3: rq = make_req(ACT_SETVAL, 0, rnd16(), rnd16(), rnd16());
                    4, 5: rq = make_req(ACT_SETDER, 0, rnd16(), rnd16(), rnd16());
                    6, 7, 8: rq = make_req(ACT_READ, 4'($urandom()), rnd16(), 0, 0);
                    default: rq = make_req(ACT_EVAL, 4'($urandom()),
                                  $urandom_range(0, 3) == 0 ? rnd16()
                                  : 16'($urandom_range(0, 40000)), rnd16(), rnd16());
                endcase
                queue_req(rq);
            end
            if (ph == 5) drain_point();
        end
        queue_req(make_cfg(5'd16));

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (pending_q.size() == 0 && !holding);
        wait (expected_q.size() == 0);
        repeat (100) @(posedge clk);
        $display("Ran %0d results, %0d of them evaluations, over key counts 0 to 31.",
                 results_seen, evals_seen);
        if (errors == 0 && expected_q.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
